### hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define BDD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define BDD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BDD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BDD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/bdd_pkg.sv
`timescale 1ns / 1ps
package bdd_pkg;

  localparam int VALUE_W = 31;
  localparam int DIGIT_W = 4;
  localparam int NUM_BCD = 10;
  localparam int SHIFT_CNT_W = 5;

  localparam logic [SHIFT_CNT_W-1:0] LAST_SHIFT = SHIFT_CNT_W'(VALUE_W - 1);
  localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;
  localparam logic [DIGIT_W-1:0] DIGIT_FIVE = 4'd5;
  localparam logic [DIGIT_W-1:0] DIGIT_ADJ = 4'd3;
  localparam logic [DIGIT_W-1:0] COUNT_RESET = 4'd10;

  // all decimal digits of one value, index 0 is the least significant
  typedef logic [NUM_BCD-1:0][DIGIT_W-1:0] bcd_t;

  // queue fill status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_EMIT = 2'b10
  } back_state_t;

endpackage

### hw/rtl/binary_to_decimal_digits_saturating.sv
`timescale 1ns / 1ps
// Converts a 31-bit unsigned value to decimal digits for a display of
// digit_count positions (0 acts as 1, above MAX_DIGITS acts as MAX_DIGITS),
// most significant first, one digit per cycle on result_valid with last on
// the final position; a value with more digits than positions shows all 9s.
// The receiver cannot stall: each result is on the ports for one cycle only.
// Accepting an item keeps busy high while the bit-serial double dabble
// converter makes its 31 shifts and hands the result off; the hand-off
// waits while the queue is full. Digit output then follows in a separate
// emitter, through a two-entry queue, so a new item converts while the
// previous one is still being shown; start is taken only while busy is low.
module binary_to_decimal_digits_saturating
  import bdd_pkg::*;
#(
  parameter int MAX_DIGITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] value,
  input  logic               cfg_we,
  input  logic [DIGIT_W-1:0] cfg_data,
  output logic               result_valid,
  output logic [DIGIT_W-1:0] digit,
  output logic               last
);

  logic [DIGIT_W-1:0] digit_count;
  q_status_t          q_status;
  logic               push;
  logic               pop;
  bcd_t               push_data;
  bcd_t               pop_data;

  // display size register
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= COUNT_RESET;
    end else if (cfg_we) begin
      digit_count <= cfg_data;
    end
  end

  // converter front end
  bdd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .value     (value),
    .busy      (busy),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  // hand-off queue
  bdd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_status  (q_status)
  );

  // digit emitter
  bdd_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .pop_data     (pop_data),
    .pop          (pop),
    .digit_count  (digit_count),
    .result_valid (result_valid),
    .digit        (digit),
    .last         (last)
  );

endmodule

### hw/rtl/bdd_front.sv
`timescale 1ns / 1ps
module bdd_front
  import bdd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VALUE_W-1:0] value,
  output logic               busy,
  input  q_status_t          q_status,
  output logic               push,
  output bcd_t               push_data
);

  front_state_t            state, state_next;
  logic [VALUE_W-1:0]      shreg;
  logic [SHIFT_CNT_W-1:0]  cnt;
  bcd_t                    bcd;
  bcd_t                    adj;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_BCD; i++) begin
      adj[i] = (bcd[i] >= DIGIT_FIVE) ? bcd[i] + DIGIT_ADJ : bcd[i];
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (start) state_next = F_CONV;
      F_CONV: if (cnt == LAST_SHIFT) state_next = F_PUSH;
      F_PUSH: if (!q_status.full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // bit-serial double dabble datapath
  always_ff @(posedge clk) begin
    if (state == F_IDLE && start) begin
      shreg <= value;
      bcd   <= '0;
      cnt   <= '0;
    end else if (state == F_CONV) begin
      bcd   <= bcd_t'({adj, shreg[VALUE_W-1]});
      shreg <= {shreg[VALUE_W-2:0], 1'b0};
      cnt   <= cnt + 1'b1;
    end
  end

  assign busy      = (state != F_IDLE);
  assign push      = (state == F_PUSH) && !q_status.full;
  assign push_data = bcd;

endmodule

### hw/rtl/bdd_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bdd_queue
  import bdd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  bcd_t      push_data,
  input  logic      pop,
  output bcd_t      pop_data,
  output q_status_t q_status
);

  localparam int DEPTH = 2;
  localparam int PTR_W = 1;

  bcd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  assign pop_data       = mem[rd_ptr];
  assign q_status.full  = (count == (PTR_W+1)'(DEPTH));
  assign q_status.empty = (count == '0);

  `BDD_ASSERT_IMP(a_no_overfill, clk, rst, push, !q_status.full)
  `BDD_ASSERT_IMP(a_no_underrun, clk, rst, pop, !q_status.empty)
  `BDD_ASSERT_IMP(a_level_bound, clk, rst, 1'b1, count <= (PTR_W+1)'(DEPTH))

endmodule

### hw/rtl/bdd_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bdd_back
  import bdd_pkg::*;
#(
  parameter int MAX_DIGITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  q_status_t          q_status,
  input  bcd_t               pop_data,
  output logic               pop,
  input  logic [DIGIT_W-1:0] digit_count,
  output logic               result_valid,
  output logic [DIGIT_W-1:0] digit,
  output logic               last
);

  localparam int PW = $clog2(MAX_DIGITS + 1);
  localparam logic [DIGIT_W-1:0] MAXD = DIGIT_W'(MAX_DIGITS);

  back_state_t        state;
  logic [PW-1:0]      idx;
  logic               ovf;
  bcd_t               bcd;
  logic [DIGIT_W-1:0] pos;
  logic               ovf_load;

  // positions in use, clamped to one and to the display size
  always_comb begin
    if (digit_count == '0) begin
      pos = 4'd1;
    end else if (digit_count > MAXD) begin
      pos = MAXD;
    end else begin
      pos = digit_count;
    end
  end

  // any nonzero digit beyond the display saturates the whole item
  always_comb begin
    ovf_load = 1'b0;
    for (int i = 0; i < NUM_BCD; i++) begin
      if (pop_data[i] != '0 && DIGIT_W'(i) >= pos) ovf_load = 1'b1;
    end
  end

  assign pop = (state == B_IDLE) && !q_status.empty;

  // emit sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: if (!q_status.empty) state <= B_EMIT;
        B_EMIT: if (idx == '0) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  // item load and position countdown
  always_ff @(posedge clk) begin
    if (pop) begin
      bcd <= pop_data;
      ovf <= ovf_load;
      idx <= PW'(pos - 4'd1);
    end else if (state == B_EMIT) begin
      idx <= idx - 1'b1;
    end
  end

  assign result_valid = (state == B_EMIT);
  assign digit        = ovf ? DIGIT_NINE : bcd[DIGIT_W'(idx)];
  assign last         = (idx == '0);

  `BDD_ASSERT_IMP(a_digit_range, clk, rst, result_valid, digit <= DIGIT_NINE)
  `BDD_ASSERT_NXT(a_no_gap, clk, rst, result_valid && !last, result_valid)
  `BDD_ASSERT_NXT(a_pop_starts, clk, rst, pop, result_valid && !pop)

endmodule
